// ===== hdl/drdb_pkg.sv =====
// ----------------------------------------------------------------------------
// drdb_pkg
// Shared word types and codes for the dueling RRIP / dead block replacement.
// ----------------------------------------------------------------------------
package drdb_pkg;

   typedef struct packed {
      logic        kind;
      logic [10:0] set_index;
      logic [3:0]  way;
      logic [63:0] address;
      logic [3:0]  pc_low;
      logic        hit;
      logic        victim_present;
      logic [15:0] valid_mask;
   } req_word_type;

   typedef struct packed {
      logic [3:0] evict_way;
      logic [1:0] victim_source;
   } rsp_word_type;

   typedef enum logic {
      KIND_QUERY  = 1'b0,
      KIND_UPDATE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      SRC_INVALID = 2'd0,
      SRC_DEAD    = 2'd1,
      SRC_DISTANT = 2'd2,
      SRC_UPDATE  = 2'd3
   } source_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW,
      ST_SIG,
      ST_MOD
   } state_type;

   localparam logic [8:0] PERIOD_RESET = 9'd32;
   localparam logic [8:0] PERIOD_MAX   = 9'd256;
   localparam logic [63:0] STRIDE      = 64'd64;

endpackage

// ===== hdl/drdb_set_ram.sv =====
// ----------------------------------------------------------------------------
// drdb_set_ram
// Per-set row memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module drdb_set_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 194
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/drdb_sig_ram.sv =====
// ----------------------------------------------------------------------------
// drdb_sig_ram
// Signature outcome table: 2-bit counters, one write port, two read ports.
// ----------------------------------------------------------------------------
module drdb_sig_ram #(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [1:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [1:0]               rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [1:0]               rd_data_b
);

   logic [1:0] mem [DEPTH];
   logic [1:0] rd_a_ff;
   logic [1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hdl/dueling_rrip_dead_block_replacement.sv =====
// ----------------------------------------------------------------------------
// dueling_rrip_dead_block_replacement
// Victim selection and state update for a set-associative cache.
// ----------------------------------------------------------------------------
// After reset the block sweeps its memories and holds req_stall high
// meanwhile. The user must write the bip_period register only while
// req_stall is low and no item is in flight; the block does not enforce it.
// An item then passes ST_ROW and ST_SIG: the set row and the new signature's
// table entry are read, then the evicted signature's table entry is read,
// then, once the output register is free, the row and, where due, the table
// are written and the result word is loaded into the output register. The
// evicted entry's read follows the row read, as the row holds its signature.
// When a BIP counter was left above a newly written period, its first advance
// afterwards reduces it by repeated subtraction, one step a cycle.
// ----------------------------------------------------------------------------
module dueling_rrip_dead_block_replacement #(
   parameter int NUM_SETS     = 2048,
   parameter int NUM_WAYS     = 16,
   parameter int LEADER_SETS  = 64,
   parameter int SIG_ENTRIES  = 256,
   parameter int SELECTOR_MAX = 1023
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  drdb_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output drdb_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write,
   input  logic [8:0]             csr_data
);

   localparam int SET_AW  = $clog2(NUM_SETS);
   localparam int WAY_W   = $clog2(NUM_WAYS);
   localparam int SIG_AW  = $clog2(SIG_ENTRIES);
   localparam int SEL_W   = $clog2(SELECTOR_MAX + 1);
   localparam int CLR_N   = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
   localparam int CLR_W   = $clog2(CLR_N);
   localparam int RRPV_LO = 0;
   localparam int DEAD_LO = 2 * NUM_WAYS;
   localparam int SIGS_LO = 4 * NUM_WAYS;
   localparam int STRM_LO = 8 * NUM_WAYS;
   localparam int LAST_LO = 8 * NUM_WAYS + 2;
   localparam int ROW_W   = 8 * NUM_WAYS + 66;

   localparam logic [16:0]      LIP_LIMIT = 17'(LEADER_SETS / 2);
   localparam logic [16:0]      BIP_LIMIT = 17'(LEADER_SETS);
   localparam logic [SEL_W-1:0] SEL_TOP   = SEL_W'(SELECTOR_MAX);
   localparam logic [SEL_W-1:0] SEL_HALF  = SEL_W'(SELECTOR_MAX / 2);
   localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_N - 1);

   // x mod n by conditional subtraction of n shifted; n is a constant here
   function automatic logic [16:0] mod_const(input logic [16:0] x, input int n);
      logic [31:0] r;
      r = {15'd0, x};
      for (int k = 11; k >= 0; k--) begin
         if (r >= 32'(n << k)) begin
            r = r - 32'(n << k);
         end
      end
      return r[16:0];
   endfunction

   drdb_pkg::state_type    state_ff, state_in;
   drdb_pkg::req_word_type req_ff;
   drdb_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SET_AW-1:0]      set_ff;
   logic [WAY_W-1:0]       way_ff;
   logic [SIG_AW-1:0]      idx_ff;
   logic [CLR_W-1:0]       clr_ff, clr_in;
   logic [8:0]             period_ff;
   logic [SEL_W-1:0]       sel_ff, sel_in;
   logic [7:0]             lead_cnt_ff, lead_cnt_in;
   logic [7:0]             foll_cnt_ff, foll_cnt_in;
   logic [8:0]             mod_ff, mod_in;
   logic                   mod_foll_ff, mod_foll_in;

   logic                   req_fire;
   logic [SET_AW-1:0]      set_in;
   logic [WAY_W-1:0]       way_in;
   logic [SIG_AW-1:0]      idx_in;
   logic [SIG_AW-1:0]      vidx;
   logic [3:0]             old_sig;
   logic [3:0]             new_sig;
   logic [8:0]             eff;
   logic [ROW_W-1:0]       row_q;
   logic [ROW_W-1:0]       row_d;
   logic                   row_we;
   logic [SET_AW-1:0]      row_waddr;
   logic [SET_AW-1:0]      row_raddr;
   logic [ROW_W-1:0]       row_reset;
   logic [1:0]             tbl_a;
   logic [1:0]             tbl_b;
   logic                   tbl_we;
   logic [SIG_AW-1:0]      tbl_waddr;
   logic [1:0]             tbl_d;
   logic [SIG_AW-1:0]      tbl_raddr_a;
   logic                   out_free;

   assign req_fire = req_valid && !req_stall;
   assign req_stall = (state_ff != drdb_pkg::ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign set_in = SET_AW'(mod_const({6'd0, req_word.set_index}, NUM_SETS));
   assign way_in = WAY_W'(mod_const({13'd0, req_word.way}, NUM_WAYS));
   assign idx_in = SIG_AW'(mod_const({9'd0, set_in[3:0],
                                      req_word.pc_low ^ set_in[3:0]}, SIG_ENTRIES));

   assign eff = (period_ff == 9'd0) ? 9'd1 :
                (period_ff > drdb_pkg::PERIOD_MAX) ? drdb_pkg::PERIOD_MAX : period_ff;

   // rows read at accept and held through the update
   assign row_raddr   = (state_ff == drdb_pkg::ST_IDLE) ? set_in : set_ff;
   assign tbl_raddr_a = (state_ff == drdb_pkg::ST_IDLE) ? idx_in : idx_ff;

   always_comb begin
      row_reset = '0;
      row_reset[DEAD_LO-1:RRPV_LO] = '1;
   end

   always_comb begin
      old_sig = 4'd0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (way_ff == WAY_W'(w)) begin
            old_sig = row_q[SIGS_LO + 4*w +: 4];
         end
      end
      new_sig = req_ff.pc_low ^ set_ff[3:0];
      vidx = SIG_AW'(mod_const({9'd0, set_ff[3:0], old_sig}, SIG_ENTRIES));
   end

   drdb_set_ram #(.DEPTH(NUM_SETS), .WIDTH(ROW_W)) u_set_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_d),
      .rd_addr (row_raddr),
      .rd_data (row_q)
   );

   drdb_sig_ram #(.DEPTH(SIG_ENTRIES)) u_sig_ram (
      .clock     (clock),
      .wr_en     (tbl_we),
      .wr_addr   (tbl_waddr),
      .wr_data   (tbl_d),
      .rd_addr_a (tbl_raddr_a),
      .rd_data_a (tbl_a),
      .rd_addr_b (vidx),
      .rd_data_b (tbl_b)
   );

   always_comb begin
      logic [NUM_WAYS-1:0] vld;
      logic [1:0]          rr   [NUM_WAYS];
      logic [1:0]          dd   [NUM_WAYS];
      logic [1:0]          maxv;
      logic [1:0]          add;
      logic                f_inv, f_dead, f_dist;
      logic [3:0]          w_inv, w_dead, w_dist;
      logic [1:0]          strm;
      logic [63:0]         last;
      logic [63:0]         delta;
      logic                stride;
      logic                lip_lead, bip_lead;
      logic [1:0]          ins;
      logic                bip, use_foll;
      logic [7:0]          cnt;
      logic [8:0]          nxt;

      state_in     = state_ff;
      clr_in       = clr_ff;
      sel_in       = sel_ff;
      lead_cnt_in  = lead_cnt_ff;
      foll_cnt_in  = foll_cnt_ff;
      mod_in       = mod_ff;
      mod_foll_in  = mod_foll_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      row_we       = 1'b0;
      row_waddr    = set_ff;
      row_d        = row_q;
      tbl_we       = 1'b0;
      tbl_waddr    = idx_ff;
      tbl_d        = tbl_a;

      vld = '0;
      maxv = 2'd0;
      f_inv = 1'b0; f_dead = 1'b0; f_dist = 1'b0;
      w_inv = 4'd0; w_dead = 4'd0; w_dist = 4'd0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (w < 16) begin
            vld[w] = req_ff.valid_mask[w];
         end
         rr[w] = row_q[RRPV_LO + 2*w +: 2];
         dd[w] = row_q[DEAD_LO + 2*w +: 2];
         if (rr[w] > maxv) begin
            maxv = rr[w];
         end
      end
      add = 2'd3 - maxv;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (!vld[w]) begin
            f_inv = 1'b1; w_inv = 4'(w);
         end
         if (dd[w] == 2'd0) begin
            f_dead = 1'b1; w_dead = 4'(w);
         end
         if (rr[w] + add == 2'd3) begin
            f_dist = 1'b1; w_dist = 4'(w);
         end
      end

      last   = row_q[LAST_LO +: 64];
      strm   = row_q[STRM_LO +: 2];
      delta  = (last != 64'd0) ? (req_ff.address - last) : 64'd0;
      stride = (delta == drdb_pkg::STRIDE) || (delta == (64'd0 - drdb_pkg::STRIDE));
      if (stride) begin
         strm = (strm == 2'd3) ? 2'd3 : strm + 2'd1;
      end else begin
         strm = (strm == 2'd0) ? 2'd0 : strm - 2'd1;
      end

      lip_lead = {{(17-SET_AW){1'b0}}, set_ff} < LIP_LIMIT;
      bip_lead = !lip_lead && ({{(17-SET_AW){1'b0}}, set_ff} < BIP_LIMIT);
      use_foll = !lip_lead && !bip_lead;
      bip      = bip_lead || (use_foll && (sel_ff < SEL_HALF));
      cnt      = use_foll ? foll_cnt_ff : lead_cnt_ff;
      ins      = (cnt == 8'd0) ? 2'd2 : 2'd3;
      nxt      = {1'b0, cnt} + 9'd1;

      unique case (state_ff)
         drdb_pkg::ST_CLEAR: begin
            row_we    = (32'(clr_ff) < NUM_SETS);
            row_waddr = clr_ff[SET_AW-1:0];
            row_d     = row_reset;
            tbl_we    = (32'(clr_ff) < SIG_ENTRIES);
            tbl_waddr = clr_ff[SIG_AW-1:0];
            tbl_d     = 2'd0;
            clr_in    = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = drdb_pkg::ST_IDLE;
            end
         end
         drdb_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = drdb_pkg::ST_ROW;
            end
         end
         drdb_pkg::ST_ROW: begin
            state_in = drdb_pkg::ST_SIG;
         end
         drdb_pkg::ST_SIG: begin
            if (out_free) begin
               state_in     = drdb_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               row_we       = 1'b1;
               if (req_ff.kind == drdb_pkg::KIND_QUERY) begin
                  if (f_inv) begin
                     rsp_word_in = '{evict_way: w_inv, victim_source: drdb_pkg::SRC_INVALID};
                  end else if (f_dead) begin
                     rsp_word_in = '{evict_way: w_dead, victim_source: drdb_pkg::SRC_DEAD};
                  end else begin
                     // age the whole set so the oldest way reaches distant
                     for (int w = 0; w < NUM_WAYS; w++) begin
                        row_d[RRPV_LO + 2*w +: 2] = rr[w] + add;
                     end
                     rsp_word_in = '{evict_way: f_dist ? w_dist : 4'd0,
                                     victim_source: drdb_pkg::SRC_DISTANT};
                  end
               end else begin
                  rsp_word_in = '{evict_way: 4'd0, victim_source: drdb_pkg::SRC_UPDATE};
                  row_d[LAST_LO +: 64] = req_ff.address;
                  row_d[STRM_LO +: 2]  = strm;
                  for (int w = 0; w < NUM_WAYS; w++) begin
                     if (way_ff == WAY_W'(w)) begin
                        row_d[SIGS_LO + 4*w +: 4] = new_sig;
                        if (req_ff.hit) begin
                           row_d[RRPV_LO + 2*w +: 2] = 2'd0;
                           row_d[DEAD_LO + 2*w +: 2] = (dd[w] == 2'd3) ? 2'd3 : dd[w] + 2'd1;
                        end else if (strm == 2'd3) begin
                           row_d[RRPV_LO + 2*w +: 2] = 2'd3;
                           row_d[DEAD_LO + 2*w +: 2] = 2'd0;
                        end else begin
                           row_d[RRPV_LO + 2*w +: 2] = bip ? ins : 2'd3;
                           row_d[DEAD_LO + 2*w +: 2] = (tbl_a <= 2'd1) ? 2'd0 : 2'd2;
                        end
                     end
                  end
                  if (req_ff.hit) begin
                     tbl_we    = 1'b1;
                     tbl_waddr = idx_ff;
                     tbl_d     = (tbl_a == 2'd3) ? 2'd3 : tbl_a + 2'd1;
                     if (lip_lead) begin
                        sel_in = (sel_ff == SEL_TOP) ? sel_ff : sel_ff + SEL_W'(1);
                     end else if (bip_lead) begin
                        sel_in = (sel_ff == '0) ? sel_ff : sel_ff - SEL_W'(1);
                     end
                  end else if (strm != 2'd3) begin
                     if (req_ff.victim_present) begin
                        tbl_we    = 1'b1;
                        tbl_waddr = vidx;
                        tbl_d     = (tbl_b == 2'd0) ? 2'd0 : tbl_b - 2'd1;
                     end
                     if (bip) begin
                        if (nxt > eff) begin
                           // counter left above a shorter period
                           state_in    = drdb_pkg::ST_MOD;
                           mod_in      = nxt;
                           mod_foll_in = use_foll;
                        end else if (use_foll) begin
                           foll_cnt_in = (nxt == eff) ? 8'd0 : nxt[7:0];
                        end else begin
                           lead_cnt_in = (nxt == eff) ? 8'd0 : nxt[7:0];
                        end
                     end
                  end
               end
            end
         end
         drdb_pkg::ST_MOD: begin
            if (mod_ff >= eff) begin
               mod_in = mod_ff - eff;
            end else begin
               state_in = drdb_pkg::ST_IDLE;
               if (mod_foll_ff) begin
                  foll_cnt_in = mod_ff[7:0];
               end else begin
                  lead_cnt_in = mod_ff[7:0];
               end
            end
         end
         default: begin
            state_in = drdb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drdb_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= SEL_HALF;
         lead_cnt_ff  <= 8'd0;
         foll_cnt_ff  <= 8'd0;
         period_ff    <= drdb_pkg::PERIOD_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
         lead_cnt_ff  <= lead_cnt_in;
         foll_cnt_ff  <= foll_cnt_in;
         if (csr_write) begin
            period_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      mod_ff      <= mod_in;
      mod_foll_ff <= mod_foll_in;
      if (req_fire) begin
         req_ff <= req_word;
         set_ff <= set_in;
         way_ff <= way_in;
         idx_ff <= idx_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      sel_ff <= SEL_TOP)
      else $error("policy selector above its maximum");

   a_item_walk: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == drdb_pkg::ST_ROW) ##1 (state_ff == drdb_pkg::ST_SIG))
      else $error("item did not walk row and table read stages");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == drdb_pkg::ST_SIG))
      else $error("result word loaded outside the update stage");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == drdb_pkg::ST_IDLE || state_ff == drdb_pkg::ST_ROW) |-> !row_we && !tbl_we)
      else $error("memory write while no update is due");
`endif

endmodule

// ===== tb/tb_dueling_rrip_dead_block_replacement.sv =====
// ----------------------------------------------------------------------------
// tb_dueling_rrip_dead_block_replacement
// Self-checking bench for the dueling RRIP / dead block replacement policy.
// Victim queries and update words are driven through the request channel.
// An in-bench model of the per-set rows, the signature table, the selector
// and the BIP counters predicts each response word. The checker compares it
// field by field in arrival order. Both channels are throttled at random, and
// the BIP period is reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_dueling_rrip_dead_block_replacement;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETS      = 2048;
   localparam int WAYS      = 16;
   localparam int LEADERS   = 64;
   localparam int SEL_MAX   = 1023;
   localparam int WDOG_MAX  = 20000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   drdb_pkg::req_word_type req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   drdb_pkg::rsp_word_type rsp_word;
   logic                   csr_write = 1'b0;
   logic [8:0]             csr_data = '0;

   dueling_rrip_dead_block_replacement u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // replacement state mirror
   logic [1:0]  rrpv_m   [0:SETS-1][0:WAYS-1];
   logic [1:0]  dead_m   [0:SETS-1][0:WAYS-1];
   logic [3:0]  bsig_m   [0:SETS-1][0:WAYS-1];
   logic [1:0]  stream_m [0:SETS-1];
   logic [63:0] last_addr_m [0:SETS-1];
   logic [1:0]  outcome_m [0:255];
   int          selector_m;
   int          leader_bip_m;
   int          follower_bip_m;
   int          period_m;

   drdb_pkg::rsp_word_type victim_q[$];
   int   mismatches = 0;
   int   words_sent = 0;
   int   words_checked = 0;
   int   queries_sent = 0;
   int   snd_idle_pct = 0;
   int   rcv_idle_pct = 0;
   int   idle_count = 0;
   int   hot_sets[12];

   task automatic clear_model();
      for (int s = 0; s < SETS; s++) begin
         for (int w = 0; w < WAYS; w++) begin
            rrpv_m[s][w] = 2'd3;
            dead_m[s][w] = 2'd0;
            bsig_m[s][w] = 4'd0;
         end
         stream_m[s] = 2'd0;
         last_addr_m[s] = 64'd0;
      end
      for (int i = 0; i < 256; i++) outcome_m[i] = 2'd0;
      selector_m = SEL_MAX / 2;
      leader_bip_m = 0;
      follower_bip_m = 0;
      period_m = drdb_pkg::PERIOD_RESET;
   endtask

   function automatic logic [1:0] bip_insert(ref int cnt);
      int eff;
      logic [1:0] r;
      eff = (period_m == 0) ? 1 : (period_m > 256) ? 256 : period_m;
      r = (cnt == 0) ? 2'd2 : 2'd3;
      cnt = (cnt + 1) % eff;
      return r;
   endfunction

   function automatic drdb_pkg::rsp_word_type predict_victim(drdb_pkg::req_word_type w);
      drdb_pkg::rsp_word_type r;
      int s, wy, maxv;
      logic [63:0] delta;
      logic [3:0]  sig, old_sig;
      logic [7:0]  idx, vidx;
      logic [1:0]  ins;
      s = w.set_index;
      wy = w.way;
      r.evict_way = 4'd0;
      if (w.kind == drdb_pkg::KIND_QUERY) begin
         for (int i = 0; i < WAYS; i++)
            if (!w.valid_mask[i]) begin
               r.evict_way = 4'(i); r.victim_source = drdb_pkg::SRC_INVALID; return r;
            end
         for (int i = 0; i < WAYS; i++)
            if (dead_m[s][i] == 2'd0) begin
               r.evict_way = 4'(i); r.victim_source = drdb_pkg::SRC_DEAD; return r;
            end
         maxv = 0;
         for (int i = 0; i < WAYS; i++) if (rrpv_m[s][i] > maxv) maxv = rrpv_m[s][i];
         for (int i = 0; i < WAYS; i++) rrpv_m[s][i] = 2'(rrpv_m[s][i] + (3 - maxv));
         r.victim_source = drdb_pkg::SRC_DISTANT;
         for (int i = 0; i < WAYS; i++)
            if (rrpv_m[s][i] == 2'd3) begin
               r.evict_way = 4'(i); return r;
            end
         return r;
      end
      r.victim_source = drdb_pkg::SRC_UPDATE;
      delta = (last_addr_m[s] != 0) ? w.address - last_addr_m[s] : 64'd0;
      last_addr_m[s] = w.address;
      if (delta == drdb_pkg::STRIDE || delta == -drdb_pkg::STRIDE) begin
         if (stream_m[s] < 3) stream_m[s]++;
      end else if (stream_m[s] > 0) begin
         stream_m[s]--;
      end
      sig = w.pc_low ^ s[3:0];
      old_sig = bsig_m[s][wy];
      idx = {s[3:0], sig};
      bsig_m[s][wy] = sig;
      if (w.hit) begin
         rrpv_m[s][wy] = 2'd0;
         if (dead_m[s][wy] < 3) dead_m[s][wy]++;
         if (outcome_m[idx] < 3) outcome_m[idx]++;
         if (s < LEADERS / 2) begin
            if (selector_m < SEL_MAX) selector_m++;
         end else if (s < LEADERS) begin
            if (selector_m > 0) selector_m--;
         end
         return r;
      end
      if (stream_m[s] == 2'd3) begin
         rrpv_m[s][wy] = 2'd3;
         dead_m[s][wy] = 2'd0;
         return r;
      end
      if (s < LEADERS / 2) ins = 2'd3;
      else if (s < LEADERS) ins = bip_insert(leader_bip_m);
      else if (selector_m >= SEL_MAX / 2) ins = 2'd3;
      else ins = bip_insert(follower_bip_m);
      dead_m[s][wy] = (outcome_m[idx] <= 1) ? 2'd0 : 2'd2;
      rrpv_m[s][wy] = ins;
      if (w.victim_present) begin
         vidx = {s[3:0], old_sig};
         if (outcome_m[vidx] > 0) outcome_m[vidx]--;
      end
      return r;
   endfunction

   // one request word; valid stays high between back-to-back words
   task automatic send_word(drdb_pkg::req_word_type w);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      victim_q.push_back(predict_victim(w));
      words_sent++;
      if (w.kind == drdb_pkg::KIND_QUERY) queries_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (victim_q.size() != 0) @(posedge clock);
   endtask

   // the block must be idle, not still reducing a BIP counter
   task automatic write_period(logic [8:0] v);
      drain();
      repeat (8) @(posedge clock);
      while (req_stall) @(posedge clock);
      csr_write <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      period_m = v;
   endtask

   function automatic drdb_pkg::req_word_type make_query(int s, logic [15:0] mask);
      drdb_pkg::req_word_type w;
      w = '0;
      w.kind = drdb_pkg::KIND_QUERY;
      w.set_index = 11'(s);
      w.valid_mask = mask;
      w.address = {$urandom, $urandom};
      w.way = 4'($urandom_range(15));
      w.pc_low = 4'($urandom_range(15));
      return w;
   endfunction

   function automatic drdb_pkg::req_word_type make_update(int s, int wy, logic [63:0] a,
                                                          int pc, bit h, bit vp);
      drdb_pkg::req_word_type w;
      w = '0;
      w.kind = drdb_pkg::KIND_UPDATE;
      w.set_index = 11'(s);
      w.way = 4'(wy);
      w.address = a;
      w.pc_low = 4'(pc);
      w.hit = h;
      w.victim_present = vp;
      w.valid_mask = 16'($urandom);
      return w;
   endfunction

   task automatic test_query_corners();
      send_word(make_query(0, 16'h0000));
      send_word(make_query(2047, 16'h7fff));
      send_word(make_query(5, 16'hfffe));
      send_word(make_query(100, 16'hffff));      // all dead after reset
      // fill every way of a follower with trained signatures, then age it
      for (int i = 0; i < WAYS; i++)
         send_word(make_update(70, i, 64'h1000 + i * 4096, 3, 1'b1, 1'b0));
      send_word(make_query(70, 16'hffff));
      send_word(make_query(70, 16'hffff));
   endtask

   task automatic test_update_corners();
      send_word(make_update(2047, 15, 64'hffff_ffff_ffff_ffff, 15, 1'b0, 1'b1));
      send_word(make_update(2047, 15, 64'h0, 0, 1'b0, 1'b1));
      send_word(make_update(31, 0, 64'h40, 1, 1'b1, 1'b0));   // LIP leader hit
      send_word(make_update(32, 1, 64'h80, 2, 1'b1, 1'b0));   // BIP leader hit
      send_word(make_update(63, 2, 64'h3000, 4, 1'b0, 1'b1));
      send_word(make_update(64, 3, 64'h5000, 8, 1'b0, 1'b0));
   endtask

   task automatic test_stream_bypass();
      // rising then falling stride of one line, then a break
      for (int i = 0; i < 5; i++)
         send_word(make_update(200, i, 64'h10000 + i * 64, 6, 1'b0, 1'b1));
      for (int i = 0; i < 4; i++)
         send_word(make_update(200, 8 + i, 64'h10000 - i * 64, 6, 1'b0, 1'b1));
      send_word(make_update(200, 9, 64'h9999_0000, 6, 1'b0, 1'b1));
   endtask

   task automatic test_random(int n);
      drdb_pkg::req_word_type w;
      int s;
      logic [63:0] a;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(9) == 0) begin
            w = 102'({$urandom, $urandom, $urandom, $urandom});
         end else begin
            s = hot_sets[$urandom_range(11)];
            if ($urandom_range(99) < 35) begin
               w = make_query(s, ($urandom_range(9) < 7) ? 16'hffff : 16'($urandom));
            end else begin
               case ($urandom_range(3))
                  0: a = {$urandom, $urandom};
                  1: a = last_addr_m[s] - drdb_pkg::STRIDE;
                  default: a = last_addr_m[s] + drdb_pkg::STRIDE;
               endcase
               w = make_update(s, $urandom_range(15), a, $urandom_range(15),
                               1'($urandom_range(1)), 1'($urandom_range(1)));
            end
         end
         send_word(w);
         if ($urandom_range(99) == 0) drain();
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
   end

   always @(posedge clock) begin
      drdb_pkg::rsp_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (victim_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %p", rsp_word);
         end else begin
            exp_w = victim_q.pop_front();
            words_checked++;
            if (rsp_word.evict_way !== exp_w.evict_way ||
                rsp_word.victim_source !== exp_w.victim_source) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word %0d: way exp %0d got %0d, source exp %0d got %0d",
                           words_checked, exp_w.evict_way, rsp_word.evict_way,
                           exp_w.victim_source, rsp_word.victim_source);
            end
         end
      end
   end

   // no progress on either channel for too long ends the run
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= WDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      clear_model();
      hot_sets = '{0, 31, 32, 63, 64, 2047, 7, 40, 300, 1500, 1024, 65};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_period(9'd1);
      snd_idle_pct = 20; rcv_idle_pct = 56;
      test_query_corners();
      test_update_corners();
      test_stream_bypass();
      write_period(9'd3);
      test_random(170);
      write_period(9'd256);
      snd_idle_pct = 56; rcv_idle_pct = 20;
      test_random(170);
      write_period(9'd0);
      test_random(40);
      write_period(9'd511);
      snd_idle_pct = 0; rcv_idle_pct = 0;
      test_random(60);
      write_period(9'd5);
      test_random(60);
      drain();
      repeat (20) @(posedge clock);
      mismatches += victim_q.size();
      $display("%0d words sent (%0d victim queries), %0d responses checked,",
               words_sent, queries_sent, words_checked);
      $display("BIP periods 1, 3, 256, 0, 511 and 5 under three throttle mixes");
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
